@@ rtl/switch_bank_debounce_monitor_defines.svh @@
// ----------------------------------------------------------------------------
// Switch bank debounce monitor: assertion macros
// Shared property macros for the checker of the switch bank monitor.
// ----------------------------------------------------------------------------
`ifndef SWITCH_BANK_DEBOUNCE_MONITOR_DEFINES_SVH
`define SWITCH_BANK_DEBOUNCE_MONITOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbdm assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SBDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbdm assertion failed");

`endif

@@ rtl/sbdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Switch bank debounce monitor package
// Types, register indexes and constants shared by the monitor's modules.
// ----------------------------------------------------------------------------
package sbdm_pkg;

    localparam int NUM_SWITCHES = 14;

    localparam logic [15:0] SENT_MASK = 16'h0003;
    localparam logic [15:0] SENT_GOOD = 16'h0002;
    localparam logic [7:0]  SAT8      = 8'd255;

    typedef enum logic [0:0] {
        OP_INGEST = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE_SAMPLES = 3'd0,
        CFG_QUALIFY_READS    = 3'd1,
        CFG_ABSENT_READS     = 3'd2,
        CFG_CHATTER_MAX      = 3'd3,
        CFG_BUCKET_MS        = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] raw_word;
        logic [31:0] time_ms;
    } in_word_t;

    typedef struct packed {
        logic                    accepted;
        logic                    present;
        logic [NUM_SWITCHES-1:0] switch_state;
        logic [NUM_SWITCHES-1:0] changed_mask;
        logic [NUM_SWITCHES-1:0] chatter_mask;
        logic [31:0]             read_count;
        logic [31:0]             reject_count;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  debounce_samples;
        logic [7:0]  qualify_reads;
        logic [7:0]  absent_reads;
        logic [8:0]  chatter_max;
        logic [23:0] bucket_ms;
    } cfg_t;

    // Per-word decisions broadcast from the control unit to every lane.
    typedef struct packed {
        logic ingest;
        logic clear;
        logic good;
        logic first;
        logic roll;
        logic present;
        logic qualify;
        logic ever_qualified;
    } lane_ctrl_t;

    // Next values of the shared status, used to build the result word.
    typedef struct packed {
        logic        accepted;
        logic        present;
        logic [31:0] read_count;
        logic [31:0] reject_count;
    } ctrl_status_t;

endpackage

@@ rtl/sbdm_lane.sv @@
// ----------------------------------------------------------------------------
// Switch lane
// Edge buckets, chatter flag, integrator and debounced state of one switch.
// ----------------------------------------------------------------------------
module sbdm_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  sbdm_pkg::lane_ctrl_t ctrl,
    input  sbdm_pkg::cfg_t      cfg,
    input  logic                sample_bit,
    output logic                diff,
    output logic                debounced_next,
    output logic                changed_next,
    output logic                chatter_next
);

    logic [7:0] bucket_reg, bucket_next;
    logic [7:0] prev_bucket_reg, prev_bucket_next;
    logic [7:0] agree_reg, agree_next;
    logic       prev_reg, prev_next;
    logic       debounced_reg;
    logic       changed_reg;
    logic       chatter_reg;
    logic [7:0] base;
    logic [7:0] agree_inc;
    logic [8:0] total;

    always_comb
    begin
        diff             = sample_bit ^ prev_reg;
        total            = {1'b0, bucket_reg} + {1'b0, prev_bucket_reg};
        base             = ctrl.roll ? 8'd0 : bucket_reg;
        prev_bucket_next = ctrl.roll ? bucket_reg : prev_bucket_reg;
        chatter_next     = ctrl.roll ? (total > cfg.chatter_max) : chatter_reg;

        // The window roll happens first, so an edge lands in the fresh bucket.
        bucket_next = base;
        if (ctrl.ingest && ctrl.good && !ctrl.first && diff && base != sbdm_pkg::SAT8)
        begin
            bucket_next = base + 8'd1;
        end

        prev_next = (ctrl.ingest && ctrl.good) ? sample_bit : prev_reg;

        agree_inc      = (agree_reg == sbdm_pkg::SAT8) ? sbdm_pkg::SAT8 : agree_reg + 8'd1;
        agree_next     = agree_reg;
        debounced_next = debounced_reg;
        changed_next   = changed_reg;

        if (ctrl.ingest)
        begin
            if (!ctrl.good)
            begin
                agree_next = 8'd0;
            end
            else if (!ctrl.present)
            begin
                if (ctrl.qualify)
                begin
                    agree_next     = 8'd0;
                    debounced_next = sample_bit;
                    if (ctrl.ever_qualified && (sample_bit != debounced_reg))
                    begin
                        changed_next = 1'b1;
                    end
                end
            end
            else if (sample_bit == debounced_reg)
            begin
                agree_next = 8'd0;
            end
            else if (agree_inc >= cfg.debounce_samples)
            begin
                agree_next     = 8'd0;
                debounced_next = ~debounced_reg;
                changed_next   = 1'b1;
            end
            else
            begin
                agree_next = agree_inc;
            end
        end

        if (ctrl.clear)
        begin
            changed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_reg      <= '0;
            prev_bucket_reg <= '0;
            agree_reg       <= '0;
            prev_reg        <= 1'b0;
            debounced_reg   <= 1'b0;
            changed_reg     <= 1'b0;
            chatter_reg     <= 1'b0;
        end
        else
        begin
            bucket_reg      <= bucket_next;
            prev_bucket_reg <= prev_bucket_next;
            agree_reg       <= agree_next;
            prev_reg        <= prev_next;
            debounced_reg   <= debounced_next;
            changed_reg     <= changed_next;
            chatter_reg     <= chatter_next;
        end
    end

endmodule

@@ rtl/sbdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Chain control
// Sentinel check, window timing, presence qualification and word counters.
// ----------------------------------------------------------------------------
module sbdm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  sbdm_pkg::in_word_t    word,
    input  sbdm_pkg::cfg_t        cfg,
    input  logic                  any_diff,
    output sbdm_pkg::lane_ctrl_t  lane_ctrl,
    output sbdm_pkg::ctrl_status_t status
);

    logic [31:0] bucket_start_reg, bucket_start_next;
    logic [31:0] reads_reg, reads_next;
    logic [31:0] rejects_reg, rejects_next;
    logic [7:0]  bad_run_reg, bad_run_next;
    logic [7:0]  qualify_reg, qualify_next;
    logic        have_prev_reg, have_prev_next;
    logic        present_reg, present_next;
    logic        ever_reg, ever_next;
    logic [31:0] elapsed;
    logic [7:0]  qualify_new;
    logic        ingest;
    logic        good;
    logic        qualify;

    always_comb
    begin
        ingest  = fire && (word.op == sbdm_pkg::OP_INGEST);
        good    = (word.raw_word & sbdm_pkg::SENT_MASK) == sbdm_pkg::SENT_GOOD;
        elapsed = word.time_ms - bucket_start_reg;

        // A raw change or a fresh start restarts the identical-read count.
        if (!have_prev_reg || any_diff)
        begin
            qualify_new = 8'd1;
        end
        else
        begin
            qualify_new = (qualify_reg == sbdm_pkg::SAT8) ? sbdm_pkg::SAT8
                                                           : qualify_reg + 8'd1;
        end
        qualify = ingest && good && !present_reg && (qualify_new >= cfg.qualify_reads);

        lane_ctrl.ingest         = ingest;
        lane_ctrl.clear          = fire && (word.op == sbdm_pkg::OP_CLEAR);
        lane_ctrl.good           = good;
        lane_ctrl.first          = !have_prev_reg;
        lane_ctrl.roll           = ingest && (elapsed >= {8'd0, cfg.bucket_ms});
        lane_ctrl.present        = present_reg;
        lane_ctrl.qualify        = qualify;
        lane_ctrl.ever_qualified = ever_reg;

        bucket_start_next = lane_ctrl.roll ? word.time_ms : bucket_start_reg;
        reads_next        = reads_reg;
        rejects_next      = rejects_reg;
        bad_run_next      = bad_run_reg;
        qualify_next      = qualify_reg;
        have_prev_next    = have_prev_reg;
        present_next      = present_reg;
        ever_next         = ever_reg;

        if (ingest)
        begin
            reads_next = reads_reg + 32'd1;
            if (!good)
            begin
                rejects_next   = rejects_reg + 32'd1;
                qualify_next   = 8'd0;
                have_prev_next = 1'b0;
                if ((bad_run_reg < cfg.absent_reads) && (bad_run_reg != sbdm_pkg::SAT8))
                begin
                    bad_run_next = bad_run_reg + 8'd1;
                end
                if (bad_run_next >= cfg.absent_reads)
                begin
                    present_next = 1'b0;
                end
            end
            else
            begin
                bad_run_next   = 8'd0;
                have_prev_next = 1'b1;
                if (!present_reg)
                begin
                    qualify_next = qualify_new;
                    if (qualify)
                    begin
                        present_next = 1'b1;
                        ever_next    = 1'b1;
                    end
                end
            end
        end

        status.accepted     = ingest && good;
        status.present      = present_next;
        status.read_count   = reads_next;
        status.reject_count = rejects_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_start_reg <= '0;
            reads_reg        <= '0;
            rejects_reg      <= '0;
            bad_run_reg      <= '0;
            qualify_reg      <= '0;
            have_prev_reg    <= 1'b0;
            present_reg      <= 1'b0;
            ever_reg         <= 1'b0;
        end
        else
        begin
            bucket_start_reg <= bucket_start_next;
            reads_reg        <= reads_next;
            rejects_reg      <= rejects_next;
            bad_run_reg      <= bad_run_next;
            qualify_reg      <= qualify_next;
            have_prev_reg    <= have_prev_next;
            present_reg      <= present_next;
            ever_reg         <= ever_next;
        end
    end

endmodule

@@ rtl/switch_bank_debounce_monitor.sv @@
// The result word of a sample is written into the result queue when it is taken.
// One sample per cycle unless stalled; all switch lanes update in the same cycle.
// A two-entry result queue lets samples keep flowing while a result is stalled;
// sample_stall rises only when both entries are waiting.
// Reset (rst_n low, asynchronous) clears all switch, window and counter state
// and loads the register defaults; no clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
// Switch bank debounce monitor
// Top level: configuration registers, switch lanes, merge and result queue.
// ----------------------------------------------------------------------------
module switch_bank_debounce_monitor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  sbdm_pkg::in_word_t  sample_word,
    output logic                result_valid,
    input  logic                result_stall,
    output sbdm_pkg::out_word_t result_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int NSW = sbdm_pkg::NUM_SWITCHES;

    sbdm_pkg::cfg_t         cfg_reg;
    sbdm_pkg::lane_ctrl_t   lane_ctrl;
    sbdm_pkg::ctrl_status_t status;
    sbdm_pkg::out_word_t    merged;
    sbdm_pkg::out_word_t    queue_reg [2];
    logic                   wr_ptr_reg, rd_ptr_reg;
    logic [1:0]             count_reg, count_next;
    logic                   fire, pop;
    logic [NSW-1:0]         diff;
    logic [NSW-1:0]         debounced_next;
    logic [NSW-1:0]         changed_next;
    logic [NSW-1:0]         chatter_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_samples <= 8'd4;
            cfg_reg.qualify_reads    <= 8'd4;
            cfg_reg.absent_reads     <= 8'd3;
            cfg_reg.chatter_max      <= 9'd20;
            cfg_reg.bucket_ms        <= 24'd500;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sbdm_pkg::cfg_idx_t'(cfg_index))
                sbdm_pkg::CFG_DEBOUNCE_SAMPLES: cfg_reg.debounce_samples <= cfg_data[7:0];
                sbdm_pkg::CFG_QUALIFY_READS:    cfg_reg.qualify_reads    <= cfg_data[7:0];
                sbdm_pkg::CFG_ABSENT_READS:     cfg_reg.absent_reads     <= cfg_data[7:0];
                sbdm_pkg::CFG_CHATTER_MAX:      cfg_reg.chatter_max      <= cfg_data[8:0];
                sbdm_pkg::CFG_BUCKET_MS:        cfg_reg.bucket_ms        <= cfg_data;
                default: ;
            endcase
        end
    end

    assign fire         = sample_valid && !sample_stall;
    assign pop          = result_valid && !result_stall;
    assign sample_stall = (count_reg == 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result_word  = queue_reg[rd_ptr_reg];

    sbdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .word      (sample_word),
        .cfg       (cfg_reg),
        .any_diff  (|diff),
        .lane_ctrl (lane_ctrl),
        .status    (status)
    );

    // The switch bits are the inverted raw bits above the two sentinels.
    for (genvar i = 0; i < NSW; i++)
    begin : g_lane
        sbdm_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (lane_ctrl),
            .cfg            (cfg_reg),
            .sample_bit     (~sample_word.raw_word[i+2]),
            .diff           (diff[i]),
            .debounced_next (debounced_next[i]),
            .changed_next   (changed_next[i]),
            .chatter_next   (chatter_next[i])
        );
    end

    always_comb
    begin
        merged.accepted     = status.accepted;
        merged.present      = status.present;
        merged.switch_state = debounced_next;
        merged.changed_mask = changed_next;
        merged.chatter_mask = chatter_next;
        merged.read_count   = status.read_count;
        merged.reject_count = status.reject_count;

        count_next = count_reg;
        if (fire && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !fire)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            queue_reg[wr_ptr_reg] <= merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/sbdm_checker.sv @@
// ----------------------------------------------------------------------------
// Switch bank debounce monitor checker
// Port-level properties of the monitor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "switch_bank_debounce_monitor_defines.svh"

module sbdm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_stall,
    input logic                result_valid,
    input logic                result_stall,
    input sbdm_pkg::out_word_t result_word
);

    logic result_held;

    assign result_held = result_valid && result_stall;

    // A stalled result word must be offered again unchanged.
    `SBDM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_held, result_valid && $stable(result_word))

    // After every taken sample, a result is offered in the next cycle.
    `SBDM_ASSERT_NEXT(a_result_follows, clk, rst_n, sample_valid && !sample_stall, result_valid)

    // With no result waiting, the queue has room and samples are never held off.
    `SBDM_ASSERT_NOW(a_empty_no_stall, clk, rst_n, !result_valid, !sample_stall)

endmodule

bind switch_bank_debounce_monitor sbdm_checker u_sbdm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
);

@@ verif/switch_bank_debounce_monitor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Switch bank debounce monitor testbench
// Feeds raw chain words and clear commands through the sample channel and
// keeps its own model of sentinel checking, qualification, per-switch
// debouncing and the chatter window. Every result word is checked field by
// field against the model, under random gaps, random result stalls and
// several register settings.
// ----------------------------------------------------------------------------
module switch_bank_debounce_monitor_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int NSW = sbdm_pkg::NUM_SWITCHES;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    sbdm_pkg::in_word_t  sample_word = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    sbdm_pkg::out_word_t result_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [23:0]         cfg_data = '0;

    switch_bank_debounce_monitor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Register copies
    logic [7:0]  cfg_debounce_samples;
    logic [7:0]  cfg_qualify_reads;
    logic [7:0]  cfg_absent_reads;
    logic [8:0]  cfg_chatter_max;
    logic [23:0] cfg_bucket_ms;

    // Switch bank state as the block should hold it
    logic [7:0]     bucket_now  [NSW];
    logic [7:0]     bucket_last [NSW];
    logic [7:0]     flip_run    [NSW];
    logic [NSW-1:0] chatter_bits;
    logic [NSW-1:0] last_sample;
    logic [NSW-1:0] stable_state;
    logic [NSW-1:0] changed_bits;
    logic [31:0]    window_start;
    logic [31:0]    ingest_total;
    logic [31:0]    reject_total;
    logic [7:0]     bad_streak;
    logic [7:0]     qual_run;
    bit             sample_held;
    bit             chain_present;
    bit             qualified_once;

    sbdm_pkg::in_word_t  pending_samples[$];
    sbdm_pkg::out_word_t expected_results[$];
    sbdm_pkg::out_word_t oldest_result;

    bit  failed = 1'b0;
    bit  sample_accepted = 1'b0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  feed_quiet = 0;
    int  drain_quiet = 0;

    logic [NSW-1:0] stim_pattern;
    logic [31:0]    stim_time;

    function automatic sbdm_pkg::out_word_t predict_result(sbdm_pkg::in_word_t w);
        sbdm_pkg::out_word_t r;
        logic [NSW-1:0]      seen;
        logic [NSW-1:0]      edges;
        logic [NSW-1:0]      flagged;
        logic [8:0]          total;
        logic [8:0]          run;
        bit                  fresh;
        r = '0;
        if (w.op == sbdm_pkg::OP_CLEAR)
        begin
            changed_bits = '0;
        end
        else
        begin
            // The window roll is checked on every ingest, good word or not.
            if (w.time_ms - window_start >= {8'd0, cfg_bucket_ms})
            begin
                flagged = '0;
                for (int i = 0; i < NSW; i++)
                begin
                    total = {1'b0, bucket_now[i]} + {1'b0, bucket_last[i]};
                    if (total > cfg_chatter_max)
                        flagged[i] = 1'b1;
                    bucket_last[i] = bucket_now[i];
                    bucket_now[i] = '0;
                end
                chatter_bits = flagged;
                window_start = w.time_ms;
            end
            ingest_total = ingest_total + 32'd1;
            if ((w.raw_word & sbdm_pkg::SENT_MASK) != sbdm_pkg::SENT_GOOD)
            begin
                reject_total = reject_total + 32'd1;
                for (int i = 0; i < NSW; i++)
                    flip_run[i] = '0;
                qual_run = '0;
                sample_held = 1'b0;
                if (bad_streak < cfg_absent_reads && bad_streak != sbdm_pkg::SAT8)
                    bad_streak = bad_streak + 8'd1;
                if (bad_streak >= cfg_absent_reads)
                    chain_present = 1'b0;
            end
            else
            begin
                r.accepted = 1'b1;
                bad_streak = '0;
                seen = ~w.raw_word[15:2];
                fresh = !sample_held;
                edges = fresh ? '0 : (seen ^ last_sample);
                for (int i = 0; i < NSW; i++)
                begin
                    if (edges[i] && bucket_now[i] != sbdm_pkg::SAT8)
                        bucket_now[i] = bucket_now[i] + 8'd1;
                end
                last_sample = seen;
                sample_held = 1'b1;
                if (!chain_present)
                begin
                    if (fresh || edges != '0)
                        qual_run = 8'd1;
                    else if (qual_run != sbdm_pkg::SAT8)
                        qual_run = qual_run + 8'd1;
                    if (qual_run >= cfg_qualify_reads)
                    begin
                        // Only a requalification reports what moved while absent.
                        if (qualified_once)
                            changed_bits = changed_bits | (seen ^ stable_state);
                        stable_state = seen;
                        chain_present = 1'b1;
                        qualified_once = 1'b1;
                        for (int i = 0; i < NSW; i++)
                            flip_run[i] = '0;
                    end
                end
                else
                begin
                    for (int i = 0; i < NSW; i++)
                    begin
                        if (seen[i] == stable_state[i])
                        begin
                            flip_run[i] = '0;
                        end
                        else
                        begin
                            run = {1'b0, flip_run[i]} + 9'd1;
                            if (run > {1'b0, sbdm_pkg::SAT8})
                                run = {1'b0, sbdm_pkg::SAT8};
                            flip_run[i] = run[7:0];
                            if (run >= {1'b0, cfg_debounce_samples})
                            begin
                                flip_run[i] = '0;
                                stable_state[i] = ~stable_state[i];
                                changed_bits[i] = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        r.present      = chain_present;
        r.switch_state = stable_state;
        r.changed_mask = changed_bits;
        r.chatter_mask = chatter_bits;
        r.read_count   = ingest_total;
        r.reject_count = reject_total;
        return r;
    endfunction

    // Mostly short idles, a few long ones, and now and then a stretch with none.
    function automatic int pick_idle(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        $display("%0t: %s expected %h got %h", $time, field, exp_v, act_v);
        failed = 1'b1;
    endtask

    task automatic push_sample(sbdm_pkg::op_t op, logic [15:0] raw, logic [31:0] stamp);
        sbdm_pkg::in_word_t w;
        w.op = op;
        w.raw_word = raw;
        w.time_ms = stamp;
        pending_samples.push_back(w);
    endtask

    task automatic write_reg(sbdm_pkg::cfg_idx_t idx, logic [23:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            sbdm_pkg::CFG_DEBOUNCE_SAMPLES: cfg_debounce_samples = value[7:0];
            sbdm_pkg::CFG_QUALIFY_READS:    cfg_qualify_reads = value[7:0];
            sbdm_pkg::CFG_ABSENT_READS:     cfg_absent_reads = value[7:0];
            sbdm_pkg::CFG_CHATTER_MAX:      cfg_chatter_max = value[8:0];
            sbdm_pkg::CFG_BUCKET_MS:        cfg_bucket_ms = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Switch patterns that hold for a while, with bounces, chatter storms,
    // bursts of bad words and clear commands mixed in. A calm phase holds one
    // pattern so that long qualification counts can complete.
    task automatic random_phase(int count, bit calm, int lead_bad);
        int             r;
        int             storm;
        int             bad_burst;
        logic [1:0]     sent;
        logic [NSW-1:0] storm_mask;
        logic [NSW-1:0] shown;
        logic [NSW-1:0] one_bit;
        storm = 0;
        storm_mask = '0;
        bad_burst = lead_bad;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 999);
            if (r < 15)
                stim_time = $urandom;
            else if (r < 45)
                stim_time += $urandom_range(0, 600);
            else
                stim_time += $urandom_range(0, 12);
            one_bit = '0;
            one_bit[$urandom_range(0, NSW - 1)] = 1'b1;
            if (bad_burst > 0 || (!calm && r >= 60 && r < 90))
            begin
                if (bad_burst > 0)
                    bad_burst--;
                else
                    bad_burst = $urandom_range(0, 5);
                sent = 2'($urandom_range(0, 2));
                if (sent == 2'b10)
                    sent = 2'b11;
                push_sample(sbdm_pkg::OP_INGEST, {14'($urandom), sent}, stim_time);
            end
            else if (!calm && r >= 90 && r < 115)
            begin
                push_sample(sbdm_pkg::OP_CLEAR, 16'($urandom), $urandom);
            end
            else
            begin
                if (!calm && storm == 0 && $urandom_range(0, 99) < 2)
                begin
                    storm = $urandom_range(8, 40);
                    storm_mask = 14'($urandom) | one_bit;
                end
                if (!calm && $urandom_range(0, 99) < 6)
                    stim_pattern = stim_pattern ^ (($urandom_range(0, 3) == 0) ?
                                                   14'($urandom) : one_bit);
                shown = stim_pattern;
                if (storm > 0)
                begin
                    storm--;
                    if (storm % 2 == 1)
                        shown = shown ^ storm_mask;
                end
                else if (!calm && $urandom_range(0, 99) < 10)
                begin
                    shown = shown ^ one_bit;
                end
                push_sample(sbdm_pkg::OP_INGEST, {~shown, 2'b10}, stim_time);
            end
        end
    endtask

    // Sample side: a new word goes out only once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!sample_valid || sample_accepted))
        begin
            if (gap_left > 0)
            begin
                sample_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_samples.size() != 0)
            begin
                sample_word <= pending_samples.pop_front();
                sample_valid <= 1'b1;
                gap_left = pick_idle(feed_quiet);
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
            stall_left = pick_idle(drain_quiet);
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // The result is checked before the same edge's sample is predicted, so a
    // word taken at this edge can never satisfy a result leaving at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t: run timed out", $time);
                $display("tb: failure");
                $finish;
            end
            else
            begin
                if (result_valid && !result_stall)
                begin
                    if (expected_results.size() == 0)
                    begin
                        $display("%0t: result word %h with nothing expected", $time, result_word);
                        failed = 1'b1;
                    end
                    else
                    begin
                        oldest_result = expected_results.pop_front();
                        if (result_word.accepted !== oldest_result.accepted)
                            report_field("accepted", 32'(oldest_result.accepted),
                                         32'(result_word.accepted));
                        if (result_word.present !== oldest_result.present)
                            report_field("present", 32'(oldest_result.present),
                                         32'(result_word.present));
                        if (result_word.switch_state !== oldest_result.switch_state)
                            report_field("switch_state", 32'(oldest_result.switch_state),
                                         32'(result_word.switch_state));
                        if (result_word.changed_mask !== oldest_result.changed_mask)
                            report_field("changed_mask", 32'(oldest_result.changed_mask),
                                         32'(result_word.changed_mask));
                        if (result_word.chatter_mask !== oldest_result.chatter_mask)
                            report_field("chatter_mask", 32'(oldest_result.chatter_mask),
                                         32'(result_word.chatter_mask));
                        if (result_word.read_count !== oldest_result.read_count)
                            report_field("read_count", oldest_result.read_count,
                                         result_word.read_count);
                        if (result_word.reject_count !== oldest_result.reject_count)
                            report_field("reject_count", oldest_result.reject_count,
                                         result_word.reject_count);
                    end
                end
                if (sample_valid && !sample_stall)
                    expected_results.push_back(predict_result(sample_word));
                sample_accepted <= sample_valid && !sample_stall;
            end
        end
    end

    initial
    begin
        cfg_debounce_samples = 8'd4;
        cfg_qualify_reads = 8'd4;
        cfg_absent_reads = 8'd3;
        cfg_chatter_max = 9'd20;
        cfg_bucket_ms = 24'd500;
        for (int i = 0; i < NSW; i++)
        begin
            bucket_now[i] = '0;
            bucket_last[i] = '0;
            flip_run[i] = '0;
        end
        chatter_bits = '0;
        last_sample = '0;
        stable_state = '0;
        changed_bits = '0;
        window_start = '0;
        ingest_total = '0;
        reject_total = '0;
        bad_streak = '0;
        qual_run = '0;
        sample_held = 1'b0;
        chain_present = 1'b0;
        qualified_once = 1'b0;
        stim_pattern = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Clear on an empty block, then each bad sentinel pattern until absent.
        push_sample(sbdm_pkg::OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
        push_sample(sbdm_pkg::OP_INGEST, 16'h0000, 32'd0);
        push_sample(sbdm_pkg::OP_INGEST, 16'hFFFF, 32'd1);
        push_sample(sbdm_pkg::OP_INGEST, 16'h0001, 32'd2);
        // All switches closed until the chain first qualifies.
        for (int i = 0; i < 4; i++)
            push_sample(sbdm_pkg::OP_INGEST, 16'h0002, 32'd3 + 32'(i));
        // All switches open long enough to flip every one.
        for (int i = 0; i < 4; i++)
            push_sample(sbdm_pkg::OP_INGEST, 16'hFFFE, 32'd10 + 32'(i));
        // A single bounce on one switch must not flip it.
        push_sample(sbdm_pkg::OP_INGEST, 16'hFFF6, 32'd20);
        push_sample(sbdm_pkg::OP_INGEST, 16'hFFFE, 32'd21);
        // Window rolls, then a time step across the wrap of the millisecond time.
        push_sample(sbdm_pkg::OP_INGEST, 16'hFFFE, 32'd600);
        push_sample(sbdm_pkg::OP_INGEST, 16'hFFFE, 32'hFFFF_FFF0);
        push_sample(sbdm_pkg::OP_INGEST, 16'hFFFE, 32'h0000_0005);
        push_sample(sbdm_pkg::OP_CLEAR, 16'h0000, 32'h0000_0000);
        // Lose the chain, then requalify on a different pattern.
        push_sample(sbdm_pkg::OP_INGEST, 16'h1234, 32'd6);
        push_sample(sbdm_pkg::OP_INGEST, 16'h5555, 32'd7);
        push_sample(sbdm_pkg::OP_INGEST, 16'hAAAB, 32'd8);
        for (int i = 0; i < 4; i++)
            push_sample(sbdm_pkg::OP_INGEST, 16'h5556, 32'd9 + 32'(i));
        stim_time = 32'd20;
        stim_pattern = ~14'h1555;
        wait_idle();

        random_phase(230, 1'b0, 0);
        wait_idle();

        write_reg(sbdm_pkg::CFG_DEBOUNCE_SAMPLES, 24'($urandom_range(2, 6)));
        write_reg(sbdm_pkg::CFG_QUALIFY_READS, 24'($urandom_range(2, 8)));
        write_reg(sbdm_pkg::CFG_ABSENT_READS, 24'($urandom_range(1, 4)));
        write_reg(sbdm_pkg::CFG_CHATTER_MAX, 24'($urandom_range(0, 30)));
        write_reg(sbdm_pkg::CFG_BUCKET_MS, 24'($urandom_range(20, 400)));
        random_phase(200, 1'b0, 0);
        wait_idle();

        write_reg(sbdm_pkg::CFG_DEBOUNCE_SAMPLES, 24'd1);
        write_reg(sbdm_pkg::CFG_QUALIFY_READS, 24'd1);
        write_reg(sbdm_pkg::CFG_ABSENT_READS, 24'd1);
        write_reg(sbdm_pkg::CFG_CHATTER_MAX, 24'd0);
        write_reg(sbdm_pkg::CFG_BUCKET_MS, 24'd1);
        random_phase(180, 1'b0, 0);
        wait_idle();

        // One bad word drops the chain, then a steady pattern must requalify
        // through a qualification count of 250 reads.
        write_reg(sbdm_pkg::CFG_DEBOUNCE_SAMPLES, 24'd255);
        write_reg(sbdm_pkg::CFG_QUALIFY_READS, 24'd250);
        write_reg(sbdm_pkg::CFG_ABSENT_READS, 24'd1);
        write_reg(sbdm_pkg::CFG_CHATTER_MAX, 24'd510);
        write_reg(sbdm_pkg::CFG_BUCKET_MS, 24'hFF_FFFF);
        random_phase(280, 1'b1, 1);
        wait_idle();

        write_reg(sbdm_pkg::CFG_DEBOUNCE_SAMPLES, 24'd3);
        write_reg(sbdm_pkg::CFG_QUALIFY_READS, 24'd3);
        write_reg(sbdm_pkg::CFG_ABSENT_READS, 24'd255);
        write_reg(sbdm_pkg::CFG_CHATTER_MAX, 24'($urandom_range(4, 12)));
        write_reg(sbdm_pkg::CFG_BUCKET_MS, 24'd50);
        random_phase(180, 1'b0, 0);
        wait_idle();

        repeat (10) @(posedge clk);
        if (!failed && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sbdm_pkg.sv
rtl/sbdm_lane.sv
rtl/sbdm_ctrl.sv
rtl/switch_bank_debounce_monitor.sv
rtl/sbdm_checker.sv
verif/switch_bank_debounce_monitor_tb.sv
